// File: design/text_console_writer_top_assert.svh
// Assertion macros for the text console writer top level.
// Depends on nothing; the using module must have clk and rst_n in scope.
`ifndef TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define TCW_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("text console writer check failed");
`define TCW_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("text console writer check failed");
`else
`define TCW_ASSERT_NOW(label, ante, cons)
`define TCW_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: design/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_dp and text_console_writer_top; depends on nothing.
package tcw_pkg;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0]  RESET_COLOR  = 4'd7;
    localparam logic [15:0] CELL_DEFAULT = 16'h0720;
    localparam logic [15:0] CELL_BLANK   = 16'h0020;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_addr;
    } req_t;

    typedef struct packed {
        logic [10:0] cursor_pos;
        logic [15:0] cell_value;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_NL,
        OP_CR,
        OP_BS,
        OP_TAB,
        OP_CHAR,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        WSEL_DEFAULT,
        WSEL_BLANK,
        WSEL_SPACE,
        WSEL_CHAR,
        WSEL_COPY
    } wsel_t;

    typedef struct packed {
        logic  accept;
        logic  col_clr;
        logic  col_inc;
        logic  col_dec;
        logic  row_inc;
        logic  home;
        logic  ptr_clr;
        logic  ptr_inc;
        logic  mem_we;
        logic  waddr_ptr;
        wsel_t wsel;
        logic  mem_re;
        logic  raddr_ptr;
        logic  load_rsp;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic col_full;
        logic col_zero;
        logic row_last;
        logic tab_end;
        logic ptr_last;
        logic ptr_copy;
        logic rsp_free;
    } sts_t;

endpackage

// File: design/text_console_writer_top.sv
// Each request gives one result; a wrap adds a new line, a scroll copies each row below
// the first up and blanks the last row, and clear refills the whole screen.
// Throughput: one request in flight; next one taken the cycle after the result loads.
// Rate is set by the single-port-write screen memory and the sequencer steps.
// Reset: async active low; cursor home, color 7, then a fill
// of the screen during which no request is taken (config still accepted).
module text_console_writer_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  tcw_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data
);
    import tcw_pkg::*;

    `include "text_console_writer_top_assert.svh"

    cmd_t dp_cmd;
    sts_t dp_sts;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (dp_cmd),
        .sts       (dp_sts)
    );

    `TCW_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)
    `TCW_ASSERT_NEXT(a_load_shows, dp_cmd.load_rsp, rsp_valid)
    `TCW_ASSERT_NOW(a_col_bound, dp_cmd.col_inc, !dp_sts.col_full)
    `TCW_ASSERT_NOW(a_load_free, dp_cmd.load_rsp, dp_sts.rsp_free)

endmodule

// File: design/tcw_ctrl.sv
// Sequencer for the text console writer: decodes each request into cursor
// moves, cell writes and reads, scroll and clear sweeps. Depends on tcw_pkg.
module tcw_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output tcw_pkg::cmd_t cmd,
    input  tcw_pkg::sts_t sts
);
    import tcw_pkg::*;

    typedef enum logic [9:0] {
        S_INIT   = 10'b00_0000_0001,
        S_IDLE   = 10'b00_0000_0010,
        S_EXEC   = 10'b00_0000_0100,
        S_NL     = 10'b00_0000_1000,
        S_SCR_RD = 10'b00_0001_0000,
        S_SCR_WR = 10'b00_0010_0000,
        S_PUT    = 10'b00_0100_0000,
        S_TAB    = 10'b00_1000_0000,
        S_FILL   = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    state_t cont_state;

    // where to go once a new line (and any scroll) is done
    always_comb
    begin
        case (sts.op)
            OP_TAB:  cont_state = S_TAB;
            OP_CHAR: cont_state = S_PUT;
            default: cont_state = S_RESP;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.wsel   = WSEL_DEFAULT;
        req_ready  = 1'b0;
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_ptr = 1'b1;
                cmd.wsel      = WSEL_DEFAULT;
                cmd.ptr_inc   = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                case (sts.op)
                    OP_CR:
                    begin
                        cmd.col_clr = 1'b1;
                        state_next  = S_RESP;
                    end
                    OP_BS:
                    begin
                        if (!sts.col_zero)
                        begin
                            cmd.col_dec = 1'b1;
                            state_next  = S_PUT;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    OP_NL:
                    begin
                        state_next = S_NL;
                    end
                    OP_TAB:
                    begin
                        state_next = sts.col_full ? S_NL : S_TAB;
                    end
                    OP_CHAR:
                    begin
                        state_next = sts.col_full ? S_NL : S_PUT;
                    end
                    OP_CLEAR:
                    begin
                        cmd.home    = 1'b1;
                        cmd.ptr_clr = 1'b1;
                        state_next  = S_FILL;
                    end
                    OP_READ:
                    begin
                        cmd.mem_re = 1'b1;
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_NL:
            begin
                cmd.col_clr = 1'b1;
                if (!sts.row_last)
                begin
                    cmd.row_inc = 1'b1;
                    state_next  = cont_state;
                end
                else
                begin
                    cmd.ptr_clr = 1'b1;
                    state_next  = S_SCR_RD;
                end
            end
            S_SCR_RD:
            begin
                // each row below the first is copied up one row; the last row is blanked
                if (sts.ptr_copy)
                begin
                    cmd.mem_re    = 1'b1;
                    cmd.raddr_ptr = 1'b1;
                    state_next    = S_SCR_WR;
                end
                else
                begin
                    cmd.mem_we    = 1'b1;
                    cmd.waddr_ptr = 1'b1;
                    cmd.wsel      = WSEL_SPACE;
                    cmd.ptr_inc   = 1'b1;
                    if (sts.ptr_last)
                    begin
                        state_next = cont_state;
                    end
                end
            end
            S_SCR_WR:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_ptr = 1'b1;
                cmd.wsel      = WSEL_COPY;
                cmd.ptr_inc   = 1'b1;
                state_next    = S_SCR_RD;
            end
            S_PUT:
            begin
                cmd.mem_we = 1'b1;
                if (sts.op == OP_BS)
                begin
                    cmd.wsel = WSEL_BLANK;
                end
                else
                begin
                    cmd.wsel    = WSEL_CHAR;
                    cmd.col_inc = 1'b1;
                end
                state_next = S_RESP;
            end
            S_TAB:
            begin
                cmd.mem_we  = 1'b1;
                cmd.wsel    = WSEL_SPACE;
                cmd.col_inc = 1'b1;
                if (sts.tab_end)
                begin
                    state_next = S_RESP;
                end
            end
            S_FILL:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_ptr = 1'b1;
                cmd.wsel      = WSEL_DEFAULT;
                cmd.ptr_inc   = 1'b1;
                if (sts.ptr_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: design/tcw_dp.sv
// Datapath for the text console writer: cursor, color, screen memory,
// sweep pointer and the result register. Depends on tcw_pkg.
module tcw_dp #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tcw_pkg::req_t req,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output tcw_pkg::rsp_t rsp,
    input  tcw_pkg::cmd_t cmd,
    output tcw_pkg::sts_t sts
);
    import tcw_pkg::*;

    localparam int CELL_N = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELL_N);
    localparam int POS_W  = $clog2(CELL_N + 1);
    localparam int COL_W  = $clog2(COLUMNS + 1);
    localparam int ROW_W  = $clog2(ROWS);

    logic [15:0] screen_mem [0:CELL_N-1];

    req_t              item_reg;
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [3:0]        color_reg;
    logic [3:0]        color_next;
    logic [ADDR_W-1:0] ptr_reg;
    logic [ADDR_W-1:0] ptr_next;
    logic [15:0]       rd_data_reg;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;
    rsp_t              rsp_reg;

    logic [COL_W-1:0]  col_plus;
    logic [POS_W-1:0]  cur_pos;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic [15:0]       wdata;
    logic              rd_ok;
    op_t               op;

    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        op = OP_NONE;
        case (item_reg.cmd)
            CMD_WRITE:
            begin
                case (item_reg.char_code)
                    CH_NUL:  op = OP_NONE;
                    CH_LF:   op = OP_NL;
                    CH_VT:   op = OP_NL;
                    CH_CR:   op = OP_CR;
                    CH_BS:   op = OP_BS;
                    CH_TAB:  op = OP_TAB;
                    default: op = OP_CHAR;
                endcase
            end
            CMD_CLEAR: op = OP_CLEAR;
            CMD_READ:  op = OP_READ;
            default:   op = OP_NONE;
        endcase
    end

    assign col_plus = col_reg + 1'b1;
    assign cur_pos  = POS_W'(row_reg) * POS_W'(COLUMNS) + POS_W'(col_reg);
    assign rd_ok    = int'(item_reg.cell_addr) < CELL_N;

    assign sts.op       = op;
    assign sts.col_full = col_reg >= COL_W'(COLUMNS);
    assign sts.col_zero = col_reg == '0;
    assign sts.row_last = row_reg == ROW_W'(ROWS - 1);
    assign sts.tab_end  = (col_plus[1:0] == 2'b00) || (col_plus == COL_W'(COLUMNS));
    assign sts.ptr_last = ptr_reg == ADDR_W'(CELL_N - 1);
    assign sts.ptr_copy = ptr_reg < ADDR_W'(CELL_N - COLUMNS);
    assign sts.rsp_free = !rsp_valid_reg || rsp_ready;

    assign waddr = cmd.waddr_ptr ? ptr_reg : ADDR_W'(cur_pos);
    assign raddr = cmd.raddr_ptr ? ptr_reg + ADDR_W'(COLUMNS) : ADDR_W'(item_reg.cell_addr);

    always_comb
    begin
        case (cmd.wsel)
            WSEL_DEFAULT: wdata = CELL_DEFAULT;
            WSEL_BLANK:   wdata = CELL_BLANK;
            WSEL_SPACE:   wdata = {4'h0, color_reg, CH_SPACE};
            WSEL_CHAR:    wdata = {4'h0, color_reg, item_reg.char_code};
            WSEL_COPY:    wdata = rd_data_reg;
            default:      wdata = CELL_DEFAULT;
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        if (cmd.home || cmd.col_clr)
        begin
            col_next = '0;
        end
        else if (cmd.col_inc)
        begin
            col_next = col_plus;
        end
        else if (cmd.col_dec)
        begin
            col_next = col_reg - 1'b1;
        end

        row_next = row_reg;
        if (cmd.home)
        begin
            row_next = '0;
        end
        else if (cmd.row_inc)
        begin
            row_next = row_reg + 1'b1;
        end

        // clear restores the color; config must never overlap an active request, the block does not enforce it
        color_next = color_reg;
        if (cmd.home)
        begin
            color_next = RESET_COLOR;
        end
        else if (cfg_valid)
        begin
            color_next = cfg_data;
        end

        ptr_next = ptr_reg;
        if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_rsp)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            color_reg     <= RESET_COLOR;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            color_reg     <= color_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= req;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.cursor_pos <= 11'(cur_pos);
            rsp_reg.cell_value <= (op == OP_READ && rd_ok) ? rd_data_reg : 16'h0000;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
        begin
            screen_mem[waddr] <= wdata;
        end
        if (cmd.mem_re)
        begin
            rd_data_reg <= screen_mem[raddr];
        end
    end

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for text_console_writer_top: a directed request table, then
// random request bursts under three handshake idling modes, checked against hand-set results or a screen predictor.
// Depends on tcw_pkg and the design sources only.
module testbench;
    import tcw_pkg::*;

    localparam int COLS         = 80;
    localparam int ROWS_N       = 25;
    localparam int CELLS        = COLS * ROWS_N;
    localparam int SEGMENT_REQS = 14;
    localparam int SETTLE_CYCLES = 40;

    // cmd value the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [10:0] cell_addr;
        logic [7:0]  repeats;
        logic        hand_set;  // want is typed in, not predicted
        rsp_t        want;
    } script_row_t;

    localparam int SCRIPT_LEN = 32;
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_READ,   8'h00,    11'd0,    8'd1,  1'b1, {11'd0,   CELL_DEFAULT}},
        '{CMD_READ,   8'h00,    11'd1999, 8'd1,  1'b1, {11'd0,   CELL_DEFAULT}},
        '{CMD_READ,   8'h00,    11'd2000, 8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_READ,   8'hFF,    11'd2047, 8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_UNUSED, 8'hFF,    11'd2047, 8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_NUL,   11'd0,    8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_BS,    11'd0,    8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h41,    11'd0,    8'd1,  1'b1, {11'd1,   16'h0000}},
        '{CMD_WRITE,  8'hFF,    11'd0,    8'd1,  1'b1, {11'd2,   16'h0000}},
        '{CMD_READ,   8'h00,    11'd1,    8'd1,  1'b1, {11'd2,   16'h07FF}},
        '{CMD_WRITE,  CH_BS,    11'd0,    8'd1,  1'b1, {11'd1,   16'h0000}},
        '{CMD_READ,   8'h00,    11'd1,    8'd1,  1'b1, {11'd1,   CELL_BLANK}},
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd1,  1'b1, {11'd4,   16'h0000}},
        '{CMD_WRITE,  CH_CR,    11'd0,    8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_LF,    11'd0,    8'd1,  1'b1, {11'd80,  16'h0000}},
        '{CMD_WRITE,  CH_VT,    11'd0,    8'd1,  1'b1, {11'd160, 16'h0000}},
        '{CMD_CLEAR,  8'h00,    11'd0,    8'd1,  1'b1, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h01,    11'd0,    8'd1,  1'b1, {11'd1,   16'h0000}},
        '{CMD_READ,   8'h00,    11'd0,    8'd1,  1'b1, {11'd1,   16'h0701}},
        // tabs fill row 0 to the end, then a tab on the full row
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd20, 1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        // tab from column 78 stops at the row end
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd18, 1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h7E,    11'd0,    8'd2,  1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_BS,    11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        '{CMD_READ,   8'h00,    11'd159,  8'd1,  1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h80,    11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h5A,    11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        // down to the last row and two scrolls
        '{CMD_WRITE,  CH_LF,    11'd0,    8'd24, 1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  CH_TAB,   11'd0,    8'd20, 1'b0, {11'd0,   16'h0000}},
        '{CMD_WRITE,  8'h7F,    11'd0,    8'd1,  1'b0, {11'd0,   16'h0000}},
        '{CMD_READ,   8'h00,    11'd1839, 8'd1,  1'b0, {11'd0,   16'h0000}}
    };

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_ready;
    req_t       req;
    logic       rsp_valid;
    logic       rsp_ready;
    rsp_t       rsp;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;

    logic [15:0] shadow_cells [CELLS];
    int unsigned shadow_col;
    int unsigned shadow_row;
    logic [3:0]  shadow_color;
    rsp_t        cursor_cell_due [$];
    int          mismatches = 0;
    int          send_idle_pct = 32;
    int          recv_idle_pct = 62;

    text_console_writer_top #(
        .COLUMNS(COLS),
        .ROWS   (ROWS_N)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---- screen predictor ----

    function automatic void screen_home_clear();
        for (int i = 0; i < CELLS; i++)
            shadow_cells[i] = CELL_DEFAULT;
        shadow_col   = 0;
        shadow_row   = 0;
        shadow_color = RESET_COLOR;
    endfunction

    function automatic logic [15:0] colored(logic [7:0] ch);
        return {4'h0, shadow_color, ch};
    endfunction

    function automatic void screen_put(logic [15:0] value);
        if (shadow_row < ROWS_N && shadow_col < COLS)
            shadow_cells[shadow_row * COLS + shadow_col] = value;
    endfunction

    function automatic void screen_new_line();
        if (shadow_row < ROWS_N - 1)
            shadow_row++;
        else
        begin
            for (int i = COLS; i < CELLS; i++)
                shadow_cells[i - COLS] = shadow_cells[i];
            for (int i = CELLS - COLS; i < CELLS; i++)
                shadow_cells[i] = colored(CH_SPACE);
        end
        shadow_col = 0;
    endfunction

    function automatic rsp_t console_after(req_t r);
        int unsigned pad;
        rsp_t        res;
        res.cell_value = '0;
        case (r.cmd)
            CMD_WRITE:
                case (r.char_code)
                    CH_NUL: ;
                    CH_LF, CH_VT: screen_new_line();
                    CH_CR: shadow_col = 0;
                    CH_BS:
                        if (shadow_col != 0)
                        begin
                            shadow_col--;
                            screen_put(CELL_BLANK);
                        end
                    CH_TAB:
                    begin
                        if (shadow_col >= COLS)
                            screen_new_line();
                        pad = 4 - (shadow_col % 4);
                        while (pad != 0 && shadow_col < COLS)
                        begin
                            screen_put(colored(CH_SPACE));
                            shadow_col++;
                            pad--;
                        end
                    end
                    default:
                    begin
                        if (shadow_col >= COLS)
                            screen_new_line();
                        screen_put(colored(r.char_code));
                        shadow_col++;
                    end
                endcase
            CMD_CLEAR: screen_home_clear();
            CMD_READ:
                if (r.cell_addr < CELLS)
                    res.cell_value = shadow_cells[r.cell_addr];
            default: ;
        endcase
        res.cursor_pos = 11'(shadow_row * COLS + shadow_col);
        return res;
    endfunction

    // ---- handshakes ----

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        mismatches++;
        $display("mismatch %0d at %0t: %s got 0x%0h want 0x%0h",
                 mismatches, $time, what, got, want);
    endtask

    task automatic send_request(req_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    task automatic write_color(logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid    <= 1'b0;
        shadow_color = value;
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (cursor_cell_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin : result_check
        rsp_t want;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid === 1'b1 && rsp_ready === 1'b1)
            begin
                if (cursor_cell_due.size() == 0)
                    report_mismatch("result with no request pending", rsp.cell_value, 16'h0);
                else
                begin
                    want = cursor_cell_due.pop_front();
                    if (rsp.cursor_pos !== want.cursor_pos)
                        report_mismatch("cursor_pos", 16'(rsp.cursor_pos),
                                        16'(want.cursor_pos));
                    if (rsp.cell_value !== want.cell_value)
                        report_mismatch("cell_value", rsp.cell_value, want.cell_value);
                end
            end
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : stimulus
        req_t        item;
        req_t        burst [$];
        rsp_t        predicted;
        int unsigned sent;
        int unsigned pick;
        int unsigned len;
        int unsigned here;
        logic [3:0]  color;

        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        screen_home_clear();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_LEN; i++)
            for (int k = 0; k < SCRIPT[i].repeats; k++)
            begin
                item = {SCRIPT[i].cmd, SCRIPT[i].char_code, SCRIPT[i].cell_addr};
                send_request(item);
                predicted = console_after(item);
                cursor_cell_due.push_back(SCRIPT[i].hand_set ? SCRIPT[i].want : predicted);
            end

        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle_pct = (mode == 0) ? 32 : (mode == 1) ? 62 : 0;
            recv_idle_pct = (mode == 0) ? 62 : (mode == 1) ? 32 : 0;
            for (int seg = 0; seg < 3; seg++)
            begin
                // sender holds off until the block is idle, then a new color
                wait_for_results();
                if (mode == 0 && seg == 0)
                    color = 4'd0;
                else if (mode == 0 && seg == 1)
                    color = 4'd15;
                else
                    color = 4'($urandom_range(15));
                write_color(color);
                sent = 0;
                while (sent < SEGMENT_REQS)
                begin
                    burst.delete();
                    pick = $urandom_range(99);
                    if (pick < 38)
                    begin
                        len = $urandom_range(1, 8);
                        repeat (len)
                            burst.push_back({CMD_WRITE, 8'($urandom_range(1, 255)),
                                             11'($urandom)});
                    end
                    else if (pick < 46)
                    begin
                        // long line: may wrap, and each wrap on the last row scrolls
                        len = $urandom_range(60, 100);
                        repeat (len)
                            burst.push_back({CMD_WRITE, 8'($urandom_range(8'h20, 8'hFF)),
                                             11'($urandom)});
                    end
                    else if (pick < 60)
                    begin
                        len = $urandom_range(1, 8);
                        repeat (len)
                            burst.push_back({CMD_WRITE, $urandom_range(1) ? CH_LF : CH_VT,
                                             11'($urandom)});
                    end
                    else if (pick < 65)
                        burst.push_back({CMD_WRITE, CH_CR, 11'($urandom)});
                    else if (pick < 72)
                    begin
                        len = $urandom_range(1, 4);
                        repeat (len)
                            burst.push_back({CMD_WRITE, CH_BS, 11'($urandom)});
                    end
                    else if (pick < 78)
                    begin
                        len = $urandom_range(1, 3);
                        repeat (len)
                            burst.push_back({CMD_WRITE, CH_TAB, 11'($urandom)});
                    end
                    else if (pick < 92)
                    begin
                        // half the reads land just behind the cursor
                        here = shadow_row * COLS + shadow_col;
                        if ($urandom_range(1))
                            here = (here > 4) ? here - $urandom_range(1, 4)
                                              : $urandom_range(3);
                        else
                            here = $urandom_range(2047);
                        burst.push_back({CMD_READ, 8'($urandom), 11'(here)});
                    end
                    else if (pick < 94)
                        burst.push_back({CMD_WRITE, CH_NUL, 11'($urandom)});
                    else if (pick < 96)
                        burst.push_back({CMD_UNUSED, 8'($urandom), 11'($urandom)});
                    else if (pick < 97)
                        burst.push_back({CMD_CLEAR, 8'($urandom), 11'($urandom)});
                    else
                        burst.push_back({2'($urandom_range(3)), 8'($urandom),
                                         11'($urandom)});

                    foreach (burst[j])
                    begin
                        send_request(burst[j]);
                        cursor_cell_due.push_back(console_after(burst[j]));
                        if (!(burst[j].cmd == CMD_UNUSED ||
                              (burst[j].cmd == CMD_WRITE && burst[j].char_code == CH_NUL)))
                            sent++;
                    end
                end
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #200_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/tcw_pkg.sv
design/tcw_ctrl.sv
design/tcw_dp.sv
design/text_console_writer_top.sv
tb/sv/testbench.sv
